### sv/sits_pkg.sv
// Shared types, display codes and digit helpers for the signed integer display formatter.
package sits_pkg;

  localparam logic [7:0] CMD_DP_CTRL = 8'h77;
  localparam logic [7:0] CMD_BLANK   = 8'h78;
  localparam logic [7:0] CMD_MINUS   = 8'h2D;
  localparam logic [7:0] MARK_OVER   = 8'h20;
  localparam logic [7:0] MARK_NONE   = 8'h00;

  localparam int NUM_BYTES = 6;

  // Work carried down the digit pipeline. digs[0] is the thousands digit.
  typedef struct packed {
    logic            neg;
    logic            over;
    logic            zero;
    logic [13:0]     rem;
    logic [3:0][3:0] digs;
  } pipe_t;

  // The four formatted digit bytes and the mark byte. dig[0] is sent first.
  typedef struct packed {
    logic [7:0]      mark;
    logic [3:0][7:0] dig;
  } fmt_t;

  // One decimal digit of x for a constant place value, with x below ten places.
  function automatic logic [3:0] digit_of(logic [13:0] x, logic [13:0] place);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (x >= 14'(k) * place) d = 4'(k);
    end
    return d;
  endfunction

  // Leading-blank and minus-sign rules over the four digits.
  function automatic fmt_t format_digits(pipe_t p);
    fmt_t       f;
    logic [4:0] nz;
    logic       started;
    started = 1'b0;
    nz[4]   = 1'b0;
    for (int i = 0; i < 4; i++) nz[i] = (p.digs[i] != 4'd0);
    f.mark = p.over ? MARK_OVER : MARK_NONE;
    for (int i = 0; i < 4; i++) begin
      if (started || nz[i] || (i == 3 && p.zero)) begin
        f.dig[i] = {4'd0, p.digs[i]};
        started  = 1'b1;
      end else if (p.neg && nz[i+1]) begin
        f.dig[i] = CMD_MINUS;
      end else begin
        f.dig[i] = CMD_BLANK;
      end
    end
    return f;
  endfunction

endpackage

### sv/sits_if.sv
// Handshake channels: the input number word and the output command byte word.
interface sits_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface sits_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       last;

  modport source (output valid, output cmd_byte, output last, input ready);
  modport sink (input valid, input cmd_byte, input last, output ready);
endinterface

### sv/sits_digits.sv
// Four-stage pipeline from a signed number to its magnitude's last four decimal digits.
module sits_digits (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  number,
  output logic                out_valid,
  input  logic                out_ready,
  output sits_pkg::pipe_t     out_data
);
  import sits_pkg::*;

  logic [3:0]  v;
  pipe_t       d [4];
  logic [3:0]  adv;

  logic        neg;
  logic [15:0] mag;
  logic [1:0]  tens_k;
  pipe_t       s0_next;
  pipe_t       s1_next;
  pipe_t       s2_next;
  pipe_t       s3_next;
  logic [3:0]  d1, d2, d3;

  assign adv[3] = !v[3] || out_ready;
  assign adv[2] = !v[2] || adv[3];
  assign adv[1] = !v[1] || adv[2];
  assign adv[0] = !v[0] || adv[1];
  assign in_ready = adv[0];

  // Stage 0: magnitude, overflow mark, and reduction modulo 10000.
  always_comb begin
    neg = number[15];
    mag = neg ? (16'd0 - number) : number;
    if (mag >= 16'd30000)      tens_k = 2'd3;
    else if (mag >= 16'd20000) tens_k = 2'd2;
    else if (mag >= 16'd10000) tens_k = 2'd1;
    else                       tens_k = 2'd0;
    s0_next.neg  = neg;
    s0_next.over = neg ? (mag > 16'd999) : (mag > 16'd9999);
    s0_next.zero = (mag == 16'd0);
    s0_next.rem  = 14'(mag - 16'(tens_k) * 16'd10000);
    s0_next.digs = '0;
  end

  assign d1 = digit_of(d[0].rem, 14'd1000);
  assign d2 = digit_of(d[1].rem, 14'd100);
  assign d3 = digit_of(d[2].rem, 14'd10);

  always_comb begin
    s1_next         = d[0];
    s1_next.digs[0] = d1;
    s1_next.rem     = d[0].rem - 14'(d1) * 14'd1000;
    s2_next         = d[1];
    s2_next.digs[1] = d2;
    s2_next.rem     = d[1].rem - 14'(d2) * 14'd100;
    s3_next         = d[2];
    s3_next.digs[2] = d3;
    s3_next.digs[3] = 4'(d[2].rem - 14'(d3) * 14'd10);
    s3_next.rem     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
      if (adv[3]) v[3] <= v[2];
    end
    if (adv[0]) d[0] <= s0_next;
    if (adv[1]) d[1] <= s1_next;
    if (adv[2]) d[2] <= s2_next;
    if (adv[3]) d[3] <= s3_next;
  end

  assign out_valid = v[3];
  assign out_data  = d[3];

  a_rem_thousands: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> d[0].rem < 14'd10000) else $error("remainder not reduced below 10000");
  a_rem_hundreds: assert property (@(posedge clk) disable iff (rst)
    v[1] |-> d[1].rem < 14'd1000 && d[1].digs[0] <= 4'd9)
    else $error("thousands step out of range");
  a_digits: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> d[3].digs[2] <= 4'd9 && d[3].digs[3] <= 4'd9)
    else $error("tens or units digit out of range");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v[3] && !out_ready |=> v[3] && $stable(d[3]))
    else $error("last digit stage changed while stalled");
endmodule

### sv/sits_serial.sv
// Six-byte shift register that sends one formatted word as a run of command bytes.
module sits_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sits_pkg::fmt_t in_data,
  sits_out_if.source    cmd_ch
);
  import sits_pkg::*;

  logic [7:0] sh [NUM_BYTES];
  logic [2:0] cnt;
  logic       busy;
  logic       out_fire;
  logic       done;
  logic       load;

  assign out_fire = busy && cmd_ch.ready;
  assign done     = out_fire && (cnt == 3'(NUM_BYTES - 1));
  assign in_ready = !busy || done;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (out_fire) begin
      cnt <= cnt + 3'd1;
    end
    if (load) begin
      sh[0] <= CMD_DP_CTRL;
      sh[1] <= in_data.mark;
      sh[2] <= in_data.dig[0];
      sh[3] <= in_data.dig[1];
      sh[4] <= in_data.dig[2];
      sh[5] <= in_data.dig[3];
    end else if (out_fire) begin
      for (int i = 0; i < NUM_BYTES - 1; i++) sh[i] <= sh[i+1];
      sh[NUM_BYTES-1] <= CMD_BLANK;
    end
  end

  assign cmd_ch.valid    = busy;
  assign cmd_ch.cmd_byte = sh[0];
  assign cmd_ch.last     = (cnt == 3'(NUM_BYTES - 1));

  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && cnt == 3'd0 && sh[0] == CMD_DP_CTRL)
    else $error("run did not start with the control code");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_fire && !cmd_ch.last |=> busy && cnt == $past(cnt) + 3'd1)
    else $error("run broke off before its last byte");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt < 3'(NUM_BYTES)) else $error("byte count out of range");
endmodule

### sv/signed_int_to_seven_seg_cmds.sv
// Top level: signed number in, six display command bytes out per number.
//
//   channel    dir  payload                   word
//   number_ch  in   number[15:0] signed       one number to show
//   cmd_ch     out  cmd_byte[7:0], last       one command byte, last on the sixth
//
// A number passes four digit stages, one formatting stage and the output register
// before its first byte is on cmd_ch. The output then sends six bytes; the output
// register takes the next number only as the last byte of the current one goes
// out, and the pipeline behind it holds up to five waiting numbers. Reset clears
// all valid bits and the byte count. A stall on cmd_ch holds each full stage in
// place and backs up into number_ch.ready.
module signed_int_to_seven_seg_cmds (
  input  logic       clk,
  input  logic       rst,
  sits_in_if.sink    number_ch,
  sits_out_if.source cmd_ch
);
  import sits_pkg::*;

  logic  dg_valid;
  logic  dg_ready;
  pipe_t dg_data;

  logic  fmt_v;
  fmt_t  fmt;
  logic  fmt_adv;
  logic  ser_ready;

  sits_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number_ch.valid),
    .in_ready  (number_ch.ready),
    .number    (number_ch.number),
    .out_valid (dg_valid),
    .out_ready (dg_ready),
    .out_data  (dg_data)
  );

  // Formatting stage: blanks, minus sign and mark byte.
  assign fmt_adv  = !fmt_v || ser_ready;
  assign dg_ready = fmt_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_v <= 1'b0;
    end else if (fmt_adv) begin
      fmt_v <= dg_valid;
    end
    if (fmt_adv) fmt <= format_digits(dg_data);
  end

  sits_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fmt_v),
    .in_ready (ser_ready),
    .in_data  (fmt),
    .cmd_ch   (cmd_ch)
  );

  a_fmt_hold: assert property (@(posedge clk) disable iff (rst)
    fmt_v && !ser_ready |=> fmt_v && $stable(fmt))
    else $error("formatted word changed while stalled");
  a_fmt_mark: assert property (@(posedge clk) disable iff (rst)
    fmt_v |-> fmt.mark == MARK_OVER || fmt.mark == MARK_NONE)
    else $error("bad mark byte");
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    fmt_v && !ser_ready && dg_valid |-> !dg_ready)
    else $error("digit word taken while formatting stage is stalled");
endmodule
